### rtl/bmt_pkg.sv
// Shared types and constants for the breakpoint match table.
// Holds operation and status codes, field widths and the request token type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmt_pkg;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 16;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_ENABLE = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd2;

  // Request token as it walks down the chain of slot cells.
  typedef struct packed {
    logic                valid;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   address;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot_index;
    logic                enable_value;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_taken;
    logic                hit;
    logic                count_up;
    logic                count_down;
  } bmt_req_t;

endpackage

`default_nettype wire

### rtl/bmt_cell.sv
// One breakpoint slot of the match table, with its stage of the request chain.
// Depends on bmt_pkg for the request token and the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module bmt_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire bmt_pkg::bmt_req_t req_in,
  output bmt_pkg::bmt_req_t      req_out
);
  import bmt_pkg::*;

  logic              used;
  logic              enabled;
  logic [ADDR_W-1:0] address;
  logic [KIND_W-1:0] kind;

  logic              used_next;
  logic              enabled_next;
  logic              write_entry;
  logic              slot_match;
  logic              hit_here;
  bmt_req_t          req_next;

  assign slot_match = (32'(req_in.slot_index) == CELL_INDEX);
  assign hit_here   = used && enabled && (address == req_in.address) &&
                      (kind == req_in.kind);

  always_comb begin
    req_next     = req_in;
    used_next    = used;
    enabled_next = enabled;
    write_entry  = 1'b0;
    if (req_in.valid) begin
      case (req_in.op)
        OP_ADD: begin
          if (!req_in.done && !used) begin
            req_next.done       = 1'b1;
            req_next.status     = ST_OK;
            req_next.slot_taken = SLOT_W'(CELL_INDEX);
            req_next.count_up   = 1'b1;
            used_next           = 1'b1;
            enabled_next        = 1'b1;
            write_entry         = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot_match && used) begin
            req_next.status     = ST_OK;
            req_next.count_down = 1'b1;
            used_next           = 1'b0;
            enabled_next        = 1'b0;
          end
        end
        OP_ENABLE: begin
          if (slot_match && used) begin
            req_next.status = ST_OK;
            enabled_next    = req_in.enable_value;
          end
        end
        default: begin
          if (hit_here) begin
            req_next.hit = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      enabled       <= 1'b0;
      req_out.valid <= 1'b0;
    end else if (adv) begin
      used    <= used_next;
      enabled <= enabled_next;
      req_out <= req_next;
    end
  end

  // Entry contents only matter while the slot is used, so they need no reset.
  always_ff @(posedge clk) begin
    if (adv && write_entry) begin
      address <= req_in.address;
      kind    <= req_in.kind;
    end
  end

endmodule

`default_nettype wire

### rtl/breakpoint_match_table.sv
// Breakpoint match table: top level with the chain of slot cells and result stage.
// Depends on bmt_pkg and bmt_cell.
//
// Usage: each request (add, remove, set enable or check) is offered on the
// req channel with req_valid/req_ready and yields exactly one result on the res
// channel with res_valid/res_ready. A request enters the first slot cell and
// moves one cell along the chain every cycle unless the chain holds; each cell
// applies the request to its own slot as it passes, so a request always sees
// the effect of every request accepted before it. An add claims the first free
// cell it meets, a check collects a hit from any used, enabled cell that
// matches address and kind. A request passes the register of every cell in the
// chain and then the result register before res_valid. Throughput is one
// request per cycle unless the receiver stalls; every cell is its own stage.
// When the receiver stalls (res_valid high, res_ready low) the whole chain holds
// and req_ready falls; nothing is lost and no cell changes its slot.
// Reset frees every slot, clears the used count and drops any request in flight.
// The used count is tracked at the end of the chain, in request order, and is
// reported after each operation.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_match_table #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic [bmt_pkg::OP_W-1:0]        op,
  input  wire logic [bmt_pkg::ADDR_W-1:0]      address,
  input  wire logic [bmt_pkg::KIND_W-1:0]      kind,
  input  wire logic [bmt_pkg::SLOT_W-1:0]      slot_index,
  input  wire logic                            enable_value,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output logic [bmt_pkg::STATUS_W-1:0]         status,
  output logic [bmt_pkg::SLOT_W-1:0]           slot_taken,
  output logic                                 hit,
  output logic [bmt_pkg::COUNT_W-1:0]          used_count
);
  import bmt_pkg::*;

  localparam int USED_W = $clog2(NUM_SLOTS + 1);

  logic              adv;
  bmt_req_t          chain [0:NUM_SLOTS];
  bmt_req_t          head;
  bmt_req_t          tail;
  logic [USED_W-1:0] used_total;
  logic [USED_W-1:0] used_total_next;

  // The chain and the result register move together; they hold as one
  // whenever a result is waiting and the receiver is not taking it.
  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  // Build the token for a new request. Its status starts as the answer given
  // when no cell acts on it: full for an add, unused slot for remove and
  // set enable, and ok for a check.
  always_comb begin
    head              = '0;
    head.valid        = req_valid;
    head.op           = op;
    head.address      = address;
    head.kind         = kind;
    head.slot_index   = slot_index;
    head.enable_value = enable_value;
    case (op)
      OP_ADD:    head.status = ST_FULL;
      OP_REMOVE: head.status = ST_UNUSED;
      OP_ENABLE: head.status = ST_UNUSED;
      default:   head.status = ST_OK;
    endcase
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    bmt_cell #(
      .CELL_INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .req_in  (chain[i]),
      .req_out (chain[i+1])
    );
  end

  assign tail = chain[NUM_SLOTS];

  // The used count is updated here at the end of the chain, so results carry
  // the count as it stands after their own operation.
  always_comb begin
    used_total_next = used_total;
    if (tail.valid) begin
      if (tail.count_up) begin
        used_total_next = used_total + USED_W'(1);
      end else if (tail.count_down) begin
        used_total_next = used_total - USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      used_total <= '0;
    end else if (adv) begin
      res_valid  <= tail.valid;
      used_total <= used_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status     <= tail.status;
      slot_taken <= tail.slot_taken;
      hit        <= tail.hit;
    end
  end

  assign used_count = COUNT_W'(used_total);

  // The count can never pass the number of slots.
  assert property (@(posedge clk) disable iff (rst)
    32'(used_total) <= NUM_SLOTS)
    else $error("used count exceeds the number of slots");

  // A full table is only reported when every slot is in use.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_FULL) |-> 32'(used_total) == NUM_SLOTS)
    else $error("table full reported with a free slot");

  // A hit comes only from a check, which reports ok and no slot.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && hit |-> (status == ST_OK) && (slot_taken == '0))
    else $error("hit reported with a non-check result");

  // No token may both claim a slot and free one.
  assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> !(tail.count_up && tail.count_down))
    else $error("request both added and removed a slot");

endmodule

`default_nettype wire
